// ----- rtl/swcd_pkg.sv -----
package swcd_pkg;

    localparam int MAX_HOURS = 99;

    localparam logic [5:0] MinSecMax = 6'd59;
    localparam logic [6:0] CsMax     = 7'd99;
    localparam logic [6:0] CsHalf    = 7'd50;
    localparam logic [6:0] CsRadix   = 7'd100;
    localparam logic [5:0] MsRadix   = 6'd60;

    // Key bitmap codes; a scan acts only when exactly one of them is down.
    localparam logic [7:0] KEY_STARTSTOP = 8'h80;
    localparam logic [7:0] KEY_RESET     = 8'h40;
    localparam logic [7:0] KEY_ADD_SEC   = 8'h20;
    localparam logic [7:0] KEY_ADD_MIN   = 8'h10;
    localparam logic [7:0] KEY_ADD_HOUR  = 8'h08;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_KEYS = 1'b1;

    localparam logic MODE_STOPWATCH = 1'b0;
    localparam logic MODE_COUNTDOWN = 1'b1;

    localparam logic [1:0] UNIT_SEC  = 2'd0;
    localparam logic [1:0] UNIT_MIN  = 2'd1;
    localparam logic [1:0] UNIT_HOUR = 2'd2;

    // Time is held in mixed radix, so a packed compare orders it like a tick count.
    typedef struct packed {
        logic [6:0] hh;
        logic [5:0] mm;
        logic [5:0] ss;
        logic [6:0] cs;
    } time_t;

    localparam time_t TIME_ZERO = '{hh: 7'd0, mm: 6'd0, ss: 6'd0, cs: 7'd0};
    localparam time_t TIME_MAX  = '{hh: 7'(MAX_HOURS), mm: 6'd59, ss: 6'd59, cs: 7'd99};

    typedef struct packed {
        logic  mode;
        logic  running;
        time_t elapsed;
        time_t preset;
    } state_t;

    typedef struct packed {
        logic       expired;
        logic       led;
        logic       is_on;
        logic [6:0] centiseconds;
        logic [5:0] seconds;
        logic [5:0] minutes;
        logic [6:0] hours;
    } result_t;

    // One tick forward; the caller keeps the value below TIME_MAX.
    function automatic time_t time_inc(input time_t t);
        time_t r;
        r = t;
        if (t.cs == CsMax) begin
            r.cs = 7'd0;
            if (t.ss == MinSecMax) begin
                r.ss = 6'd0;
                if (t.mm == MinSecMax) begin
                    r.mm = 6'd0;
                    r.hh = t.hh + 7'd1;
                end else begin
                    r.mm = t.mm + 6'd1;
                end
            end else begin
                r.ss = t.ss + 6'd1;
            end
        end else begin
            r.cs = t.cs + 7'd1;
        end
        return r;
    endfunction

    // Adds one second, minute or hour and saturates at TIME_MAX.
    function automatic time_t time_add(input time_t t, input logic [1:0] unit);
        time_t      r;
        logic       carry_m;
        logic       carry_h;
        logic [7:0] hh_sum;
        r       = t;
        carry_m = 1'b0;
        carry_h = 1'b0;
        hh_sum  = {1'b0, t.hh};
        if (unit == UNIT_SEC) begin
            if (t.ss == MinSecMax) begin
                r.ss    = 6'd0;
                carry_m = 1'b1;
            end else begin
                r.ss = t.ss + 6'd1;
            end
        end
        if (unit == UNIT_MIN || carry_m) begin
            if (t.mm == MinSecMax) begin
                r.mm    = 6'd0;
                carry_h = 1'b1;
            end else begin
                r.mm = t.mm + 6'd1;
            end
        end
        if (unit == UNIT_HOUR || carry_h) begin
            hh_sum = hh_sum + 8'd1;
        end
        if (hh_sum > 8'(MAX_HOURS)) begin
            r = TIME_MAX;
        end else begin
            r.hh = hh_sum[6:0];
        end
        return r;
    endfunction

    // Difference of two times with borrows between the digit groups; needs a > b.
    function automatic time_t time_sub(input time_t a, input time_t b);
        time_t      r;
        logic [7:0] cs_d;
        logic [6:0] ss_d;
        logic [6:0] mm_d;
        cs_d = {1'b0, a.cs} - {1'b0, b.cs};
        r.cs = cs_d[7] ? cs_d[6:0] + CsRadix : cs_d[6:0];
        ss_d = {1'b0, a.ss} - {1'b0, b.ss} - {6'd0, cs_d[7]};
        r.ss = ss_d[6] ? ss_d[5:0] + MsRadix : ss_d[5:0];
        mm_d = {1'b0, a.mm} - {1'b0, b.mm} - {6'd0, ss_d[6]};
        r.mm = mm_d[6] ? mm_d[5:0] + MsRadix : mm_d[5:0];
        r.hh = a.hh - b.hh - {6'd0, mm_d[6]};
        return r;
    endfunction

endpackage

// ----- rtl/swcd_core.sv -----
module swcd_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic              cfg_mode,
    input  logic              item_en,
    input  logic              item_op,
    input  logic [7:0]        item_keys,
    output swcd_pkg::state_t  state_next
);

    logic             mode_reg;
    logic             running_reg;
    swcd_pkg::time_t  elapsed_reg;
    swcd_pkg::time_t  preset_reg;
    logic [7:0]       prev_keys_reg;

    logic             running_next;
    swcd_pkg::time_t  elapsed_next;
    swcd_pkg::time_t  preset_next;
    logic [7:0]       prev_keys_next;
    logic             add_ok;

    // Add keys only take effect in countdown mode before any time has elapsed.
    assign add_ok = (mode_reg == swcd_pkg::MODE_COUNTDOWN) &&
                    (elapsed_reg == swcd_pkg::TIME_ZERO);

    always_comb begin
        running_next   = running_reg;
        elapsed_next   = elapsed_reg;
        preset_next    = preset_reg;
        prev_keys_next = prev_keys_reg;
        if (item_op == swcd_pkg::OP_TICK) begin
            if (running_reg) begin
                if (mode_reg == swcd_pkg::MODE_STOPWATCH) begin
                    if (elapsed_reg < swcd_pkg::TIME_MAX) begin
                        elapsed_next = swcd_pkg::time_inc(elapsed_reg);
                    end
                end else begin
                    if (elapsed_reg < preset_reg) begin
                        elapsed_next = swcd_pkg::time_inc(elapsed_reg);
                    end
                    if (elapsed_next >= preset_reg) begin
                        running_next = 1'b0;
                    end
                end
            end
        end else if (item_keys != prev_keys_reg) begin
            prev_keys_next = item_keys;
            case (item_keys)
                swcd_pkg::KEY_STARTSTOP: begin
                    if (running_reg) begin
                        running_next = 1'b0;
                    end else if (mode_reg == swcd_pkg::MODE_STOPWATCH ||
                                 preset_reg > elapsed_reg) begin
                        running_next = 1'b1;
                    end
                end
                swcd_pkg::KEY_RESET: begin
                    if (!running_reg) begin
                        elapsed_next = swcd_pkg::TIME_ZERO;
                    end
                end
                swcd_pkg::KEY_ADD_SEC: begin
                    if (add_ok) begin
                        preset_next = swcd_pkg::time_add(preset_reg, swcd_pkg::UNIT_SEC);
                    end
                end
                swcd_pkg::KEY_ADD_MIN: begin
                    if (add_ok) begin
                        preset_next = swcd_pkg::time_add(preset_reg, swcd_pkg::UNIT_MIN);
                    end
                end
                swcd_pkg::KEY_ADD_HOUR: begin
                    if (add_ok) begin
                        preset_next = swcd_pkg::time_add(preset_reg, swcd_pkg::UNIT_HOUR);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= swcd_pkg::MODE_STOPWATCH;
            running_reg   <= 1'b0;
            elapsed_reg   <= swcd_pkg::TIME_ZERO;
            preset_reg    <= swcd_pkg::TIME_ZERO;
            prev_keys_reg <= 8'd0;
        end else if (cfg_we) begin
            mode_reg    <= cfg_mode;
            running_reg <= 1'b0;
            elapsed_reg <= swcd_pkg::TIME_ZERO;
            preset_reg  <= swcd_pkg::TIME_ZERO;
        end else if (item_en) begin
            running_reg   <= running_next;
            elapsed_reg   <= elapsed_next;
            preset_reg    <= preset_next;
            prev_keys_reg <= prev_keys_next;
        end
    end

    assign state_next.mode    = mode_reg;
    assign state_next.running = running_next;
    assign state_next.elapsed = elapsed_next;
    assign state_next.preset  = preset_next;

endmodule

// ----- rtl/swcd_display.sv -----
module swcd_display (
    input  swcd_pkg::state_t   state,
    output swcd_pkg::result_t  result
);

    swcd_pkg::time_t shown;
    logic            countdown;

    assign countdown = (state.mode == swcd_pkg::MODE_COUNTDOWN);

    always_comb begin
        if (!countdown) begin
            shown = state.elapsed;
        end else if (state.preset > state.elapsed) begin
            shown = swcd_pkg::time_sub(state.preset, state.elapsed);
        end else begin
            shown = swcd_pkg::TIME_ZERO;
        end
    end

    assign result.hours        = shown.hh;
    assign result.minutes      = shown.mm;
    assign result.seconds      = shown.ss;
    assign result.centiseconds = shown.cs;
    assign result.is_on        = state.running;
    assign result.led          = !state.running || (shown.cs < swcd_pkg::CsHalf);
    assign result.expired      = countdown && (state.elapsed != swcd_pkg::TIME_ZERO) &&
                                 (state.elapsed >= state.preset);

endmodule

// ----- rtl/stopwatch_countdown_timer.sv -----
// An accepted input is held in the input register, and its result is offered on the
// master side from the result register. Throughput: one item per cycle while
// m_tready does not stall the output; each stage holds one item, and the state update
// plus the display split run in the single stage between input and result register.
// Reset (aresetn low, synchronous) clears both stage valids, the mode, the running
// flag, the elapsed and preset times and the remembered key bitmap.
module stopwatch_countdown_timer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,     // mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // keys[7:0]
    input  logic        s_tuser,      // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata       // hours, minutes, seconds, centiseconds,
                                      // is_on, led, expired, zero fill
);

    logic               in_valid_reg;
    logic               in_op_reg;
    logic [7:0]         in_keys_reg;
    logic               out_valid_reg;
    swcd_pkg::result_t  out_reg;

    logic               out_ready;
    logic               advance;
    logic               cfg_we;
    swcd_pkg::state_t   state_next;
    swcd_pkg::result_t  result_next;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid;
    assign out_ready = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg   <= s_tuser;
            in_keys_reg <= s_tdata;
        end
    end

    swcd_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_mode   (cfg_data),
        .item_en    (advance),
        .item_op    (in_op_reg),
        .item_keys  (in_keys_reg),
        .state_next (state_next)
    );

    swcd_display u_display (
        .state  (state_next),
        .result (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_reg};

endmodule

// ----- rtl/swcd_checker.sv -----
module swcd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // A result stays offered until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn before transfer");

    // Nothing is offered in the cycle after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result offered right after reset");

    // An expired countdown is never still running.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[28] && m_tdata[26]))
        else $error("expired while running");

    // The LED is lit whenever counting is stopped.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[26] |-> m_tdata[27])
        else $error("led dark while stopped");

    // Every displayed digit group stays within its radix.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[6:0] <= 7'd99) && (m_tdata[12:7] <= 6'd59) &&
                     (m_tdata[18:13] <= 6'd59) && (m_tdata[25:19] <= 7'd99))
        else $error("displayed time out of range");

endmodule

bind stopwatch_countdown_timer swcd_checker u_swcd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
